### rtl/quadratic_root_solver_defines.svh
// Assertion macros shared by the solver RTL.
`ifndef QUADRATIC_ROOT_SOLVER_DEFINES_SVH
`define QUADRATIC_ROOT_SOLVER_DEFINES_SVH
`ifndef SYNTHESIS
// Property that must hold at every clock edge out of reset.
`define QRS_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Condition in one cycle that implies a consequence in the next.
`define QRS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define QRS_ASSERT(label, clk, rst_n, prop, msg)
`define QRS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

### rtl/qrs_pkg.sv
package qrs_pkg;

    // Coefficient and root format.
    localparam int DW     = 32;
    localparam int FB     = 16;
    localparam int TOL_W  = 16;

    // Derived datapath widths.
    localparam int PROD_W = 2 * DW;
    localparam int D_W    = 2 * DW + 1;
    localparam int ROOT_W = DW + 1;
    localparam int TRY_W  = D_W + 2;
    localparam int NUM_W  = DW + 2;
    localparam int DEN_W  = DW + 1;
    localparam int QW     = DW;
    localparam int SCL_W  = NUM_W + FB;
    localparam int REM_W  = DEN_W + QW;
    localparam int THR_W  = TOL_W + FB;
    localparam int LANES  = 2;

    // Root count codes.
    localparam logic [1:0] CNT_NONE = 2'd0;
    localparam logic [1:0] CNT_ONE  = 2'd1;
    localparam logic [1:0] CNT_TWO  = 2'd2;
    localparam logic [1:0] CNT_INF  = 2'd3;

    localparam logic signed [DW-1:0] WORD_MAX = {1'b0, {(DW-1){1'b1}}};
    localparam logic signed [DW-1:0] WORD_MIN = {1'b1, {(DW-1){1'b0}}};

    // Which quotients the two divider lanes compute.
    typedef enum logic [2:0] {
        MODE_ZERO,
        MODE_LIN,
        MODE_DBL,
        MODE_CZERO,
        MODE_TWO
    } t_mode;

    // Data that rides alongside the square root pipeline.
    typedef struct packed {
        logic [1:0]              count;
        t_mode                   mode;
        logic signed [DW-1:0]    a;
        logic signed [DW-1:0]    b;
        logic signed [DW-1:0]    c;
    } t_sq_side;

    // One divider lane operand set.
    typedef struct packed {
        logic             neg;
        logic [NUM_W-1:0] num_mag;
        logic [DEN_W-1:0] den_mag;
    } t_lane;

    // One divider lane result.
    typedef struct packed {
        logic          ovf;
        logic          neg;
        logic [QW-1:0] mag;
    } t_quo;

endpackage

### rtl/qrs_sqrt.sv
module qrs_sqrt (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_en,
    input  logic                        i_valid,
    input  logic [qrs_pkg::D_W-1:0]     i_rad,
    input  qrs_pkg::t_sq_side           i_side,
    output logic                        o_valid,
    output logic [qrs_pkg::ROOT_W-1:0]  o_root,
    output qrs_pkg::t_sq_side           o_side
);

    logic [qrs_pkg::ROOT_W-1:0] r_v;
    logic [qrs_pkg::D_W-1:0]    r_rem  [qrs_pkg::ROOT_W];
    logic [qrs_pkg::ROOT_W-1:0] r_root [qrs_pkg::ROOT_W];
    qrs_pkg::t_sq_side          r_side [qrs_pkg::ROOT_W];

    logic [qrs_pkg::D_W-1:0]    s_rem  [qrs_pkg::ROOT_W];
    logic [qrs_pkg::ROOT_W-1:0] s_root [qrs_pkg::ROOT_W];
    qrs_pkg::t_sq_side          s_side [qrs_pkg::ROOT_W];
    logic [qrs_pkg::D_W-1:0]    n_rem  [qrs_pkg::ROOT_W];
    logic [qrs_pkg::ROOT_W-1:0] n_root [qrs_pkg::ROOT_W];

    // One root bit per stage, most significant first.
    for (genvar k = 0; k < qrs_pkg::ROOT_W; k++) begin : g_step
        localparam int BIT = qrs_pkg::ROOT_W - 1 - k;
        logic [qrs_pkg::TRY_W-1:0] w_try;
        logic                      w_take;

        if (k == 0) begin : g_first
            assign s_rem[k]  = i_rad;
            assign s_root[k] = '0;
            assign s_side[k] = i_side;
        end else begin : g_next
            assign s_rem[k]  = r_rem[k-1];
            assign s_root[k] = r_root[k-1];
            assign s_side[k] = r_side[k-1];
        end

        // Growth of the square when this bit is set: 2*q*2^i + 2^(2i).
        assign w_try = ({{(qrs_pkg::TRY_W-qrs_pkg::ROOT_W){1'b0}}, s_root[k]} << (BIT + 1))
                     | ({{(qrs_pkg::TRY_W-1){1'b0}}, 1'b1} << (2 * BIT));
        assign w_take = {2'b00, s_rem[k]} >= w_try;
        assign n_rem[k]  = w_take ? (s_rem[k] - w_try[qrs_pkg::D_W-1:0]) : s_rem[k];
        assign n_root[k] = w_take ? (s_root[k] | ({{(qrs_pkg::ROOT_W-1){1'b0}}, 1'b1} << BIT))
                                  : s_root[k];
    end

    // Valid bits travel with the data.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[qrs_pkg::ROOT_W-2:0], i_valid};
        end
    end

    // Stage payload registers.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < qrs_pkg::ROOT_W; k++) begin
                r_rem[k]  <= n_rem[k];
                r_root[k] <= n_root[k];
                r_side[k] <= s_side[k];
            end
        end
    end

    assign o_valid = r_v[qrs_pkg::ROOT_W-1];
    assign o_root  = r_root[qrs_pkg::ROOT_W-1];
    assign o_side  = r_side[qrs_pkg::ROOT_W-1];

endmodule

### rtl/qrs_div.sv
module qrs_div (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_en,
    input  logic           i_valid,
    input  qrs_pkg::t_lane i_lane [qrs_pkg::LANES],
    input  logic [1:0]     i_count,
    output logic           o_valid,
    output qrs_pkg::t_quo  o_quo [qrs_pkg::LANES],
    output logic [1:0]     o_count
);

    logic [qrs_pkg::QW:0]       r_v;
    logic [1:0]                 r0_count;
    logic [1:0]                 r_count [qrs_pkg::QW];
    logic [1:0]                 s_count [qrs_pkg::QW];

    logic [qrs_pkg::REM_W-1:0]  r0_rem [qrs_pkg::LANES];
    logic [qrs_pkg::DEN_W-1:0]  r0_den [qrs_pkg::LANES];
    logic                       r0_neg [qrs_pkg::LANES];
    logic                       r0_ovf [qrs_pkg::LANES];
    logic [qrs_pkg::REM_W-1:0]  n0_rem [qrs_pkg::LANES];
    logic                       n0_ovf [qrs_pkg::LANES];

    logic [qrs_pkg::REM_W-1:0]  r_rem [qrs_pkg::LANES][qrs_pkg::QW];
    logic [qrs_pkg::DEN_W-1:0]  r_den [qrs_pkg::LANES][qrs_pkg::QW];
    logic [qrs_pkg::QW-1:0]     r_q   [qrs_pkg::LANES][qrs_pkg::QW];
    logic                       r_neg [qrs_pkg::LANES][qrs_pkg::QW];
    logic                       r_ovf [qrs_pkg::LANES][qrs_pkg::QW];

    logic [qrs_pkg::REM_W-1:0]  s_rem [qrs_pkg::LANES][qrs_pkg::QW];
    logic [qrs_pkg::DEN_W-1:0]  s_den [qrs_pkg::LANES][qrs_pkg::QW];
    logic [qrs_pkg::QW-1:0]     s_q   [qrs_pkg::LANES][qrs_pkg::QW];
    logic                       s_neg [qrs_pkg::LANES][qrs_pkg::QW];
    logic                       s_ovf [qrs_pkg::LANES][qrs_pkg::QW];
    logic [qrs_pkg::REM_W-1:0]  n_rem [qrs_pkg::LANES][qrs_pkg::QW];
    logic [qrs_pkg::QW-1:0]     n_q   [qrs_pkg::LANES][qrs_pkg::QW];

    for (genvar l = 0; l < qrs_pkg::LANES; l++) begin : g_lane
        // Scale the numerator and flag quotients that need more than QW bits.
        assign n0_rem[l] = {{(qrs_pkg::REM_W-qrs_pkg::SCL_W){1'b0}}, i_lane[l].num_mag,
                            {qrs_pkg::FB{1'b0}}};
        assign n0_ovf[l] = n0_rem[l] >= {i_lane[l].den_mag, {qrs_pkg::QW{1'b0}}};

        // Restoring division, one quotient bit per stage.
        for (genvar k = 0; k < qrs_pkg::QW; k++) begin : g_step
            localparam int BIT = qrs_pkg::QW - 1 - k;
            logic [qrs_pkg::REM_W-1:0] w_try;
            logic                      w_take;

            if (k == 0) begin : g_first
                assign s_rem[l][k] = r0_rem[l];
                assign s_den[l][k] = r0_den[l];
                assign s_q[l][k]   = '0;
                assign s_neg[l][k] = r0_neg[l];
                assign s_ovf[l][k] = r0_ovf[l];
            end else begin : g_next
                assign s_rem[l][k] = r_rem[l][k-1];
                assign s_den[l][k] = r_den[l][k-1];
                assign s_q[l][k]   = r_q[l][k-1];
                assign s_neg[l][k] = r_neg[l][k-1];
                assign s_ovf[l][k] = r_ovf[l][k-1];
            end

            assign w_try  = {{qrs_pkg::QW{1'b0}}, s_den[l][k]} << BIT;
            assign w_take = s_rem[l][k] >= w_try;
            assign n_rem[l][k] = w_take ? (s_rem[l][k] - w_try) : s_rem[l][k];
            assign n_q[l][k]   = w_take ? (s_q[l][k] | ({{(qrs_pkg::QW-1){1'b0}}, 1'b1} << BIT))
                                        : s_q[l][k];
        end

        assign o_quo[l] = '{ovf: r_ovf[l][qrs_pkg::QW-1], neg: r_neg[l][qrs_pkg::QW-1],
                            mag: r_q[l][qrs_pkg::QW-1]};
    end

    for (genvar k = 0; k < qrs_pkg::QW; k++) begin : g_cnt
        if (k == 0) begin : g_first
            assign s_count[k] = r0_count;
        end else begin : g_next
            assign s_count[k] = r_count[k-1];
        end
    end

    // Valid bits travel with the data.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[qrs_pkg::QW-1:0], i_valid};
        end
    end

    // Stage payload registers.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r0_count <= i_count;
            for (int l = 0; l < qrs_pkg::LANES; l++) begin
                r0_rem[l] <= n0_rem[l];
                r0_den[l] <= i_lane[l].den_mag;
                r0_neg[l] <= i_lane[l].neg;
                r0_ovf[l] <= n0_ovf[l];
                for (int k = 0; k < qrs_pkg::QW; k++) begin
                    r_rem[l][k] <= n_rem[l][k];
                    r_den[l][k] <= s_den[l][k];
                    r_q[l][k]   <= n_q[l][k];
                    r_neg[l][k] <= s_neg[l][k];
                    r_ovf[l][k] <= s_ovf[l][k];
                end
            end
            for (int k = 0; k < qrs_pkg::QW; k++) begin
                r_count[k] <= s_count[k];
            end
        end
    end

    assign o_valid = r_v[qrs_pkg::QW];
    assign o_count = r_count[qrs_pkg::QW-1];

endmodule

### rtl/quadratic_root_solver.sv
// Real roots of a*x^2 + b*x + c = 0 on signed Q16.16 coefficients.
// Input channel: i_valid with i_coef_a, i_coef_b, i_coef_c; a beat is taken
// when i_valid is high and o_stall is low. Output channel: o_valid with the
// root count, both roots and the saturation flag; a beat leaves when o_valid
// is high and i_stall is low.
// The zero tolerance register is written through i_cfg_wr_en/i_cfg_wr_data
// and should only change while no beat is in flight.
// From input beat to output beat a beat passes five front stages (multiply,
// discriminant, tolerance test), 33 square root stages, two operand stages,
// 33 divider stages and the output register.
// Throughput is one beat per cycle while o_stall is low; the 33-stage root
// and 32-bit quotient pipelines set the depth, not the rate.
// When the receiver stalls, the output register holds its beat and one more
// beat lands in a skid register; o_stall then rises and the whole pipeline
// freezes until the skid drains. Nothing is dropped or repeated.
// Reset clears all valid bits and sets the zero tolerance to 1.
`include "quadratic_root_solver_defines.svh"

module quadratic_root_solver (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_wr_en,
    input  logic [qrs_pkg::TOL_W-1:0]          i_cfg_wr_data,
    input  logic                               i_valid,
    output logic                               o_stall,
    input  logic signed [qrs_pkg::DW-1:0]      i_coef_a,
    input  logic signed [qrs_pkg::DW-1:0]      i_coef_b,
    input  logic signed [qrs_pkg::DW-1:0]      i_coef_c,
    output logic                               o_valid,
    input  logic                               i_stall,
    output logic [1:0]                         o_root_count,
    output logic signed [qrs_pkg::DW-1:0]      o_root_first,
    output logic signed [qrs_pkg::DW-1:0]      o_root_second,
    output logic                               o_saturated
);

    typedef struct packed {
        logic [1:0]                   count;
        logic signed [qrs_pkg::DW-1:0] first;
        logic signed [qrs_pkg::DW-1:0] second;
        logic                         sat;
    } t_result;

    function automatic logic near_zero(input logic [qrs_pkg::DW-1:0] v,
                                       input logic [qrs_pkg::TOL_W-1:0] tol);
        logic [qrs_pkg::DW-1:0] m;
        m = v[qrs_pkg::DW-1] ? (~v + {{(qrs_pkg::DW-1){1'b0}}, 1'b1}) : v;
        return (v == '0) || (m < {{(qrs_pkg::DW-qrs_pkg::TOL_W){1'b0}}, tol});
    endfunction

    // Returns the clip flag over the signed, clipped quotient.
    function automatic logic [qrs_pkg::DW:0] clip_quo(input qrs_pkg::t_quo q);
        logic over;
        logic [qrs_pkg::DW-1:0] val;
        if (q.neg) begin
            over = q.ovf || (q.mag[qrs_pkg::QW-1] && (|q.mag[qrs_pkg::QW-2:0]));
            val  = over ? qrs_pkg::WORD_MIN : (~q.mag + {{(qrs_pkg::QW-1){1'b0}}, 1'b1});
        end else begin
            over = q.ovf || q.mag[qrs_pkg::QW-1];
            val  = over ? qrs_pkg::WORD_MAX : q.mag;
        end
        return {over, val};
    endfunction

    logic                              w_en;
    logic [qrs_pkg::TOL_W-1:0]         r_tol;

    // Zero tolerance register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tol <= {{(qrs_pkg::TOL_W-1){1'b0}}, 1'b1};
        end else if (i_cfg_wr_en) begin
            r_tol <= i_cfg_wr_data;
        end
    end

    // Stage 1: capture coefficients and their zero tests.
    logic                             r1_v;
    logic signed [qrs_pkg::DW-1:0]    r1_a, r1_b, r1_c;
    logic                             r1_nza, r1_nzb, r1_nzc;

    // Stage 2: b squared and a times c.
    logic                             r2_v;
    logic [qrs_pkg::PROD_W-1:0]       r2_bb;
    logic signed [qrs_pkg::PROD_W-1:0] r2_ac;
    logic signed [qrs_pkg::DW-1:0]    r2_a, r2_b, r2_c;
    logic                             r2_nza, r2_nzb, r2_nzc;
    logic signed [qrs_pkg::PROD_W-1:0] w_bb, w_ac;

    // Stage 3: quarter discriminant e with D = 4e + r.
    logic                             r3_v;
    logic signed [qrs_pkg::PROD_W-1:0] r3_e;
    logic                             r3_r;
    logic signed [qrs_pkg::DW-1:0]    r3_a, r3_b, r3_c;
    logic                             r3_nza, r3_nzb, r3_nzc;

    // Stage 4: magnitude of e and the radicand.
    logic                             r4_v;
    logic [qrs_pkg::PROD_W-1:0]       r4_me;
    logic                             r4_eneg, r4_ezero, r4_r;
    logic [qrs_pkg::D_W-1:0]          r4_d;
    logic signed [qrs_pkg::DW-1:0]    r4_a, r4_b, r4_c;
    logic                             r4_nza, r4_nzb, r4_nzc;

    // Stage 5: case decision.
    logic                             r5_v;
    qrs_pkg::t_sq_side                r5_side;
    logic [qrs_pkg::D_W-1:0]          r5_d;
    qrs_pkg::t_sq_side                w_side;
    logic                             w_small, w_dzero;
    logic [qrs_pkg::THR_W+1:0]        w_val;
    logic [qrs_pkg::THR_W-1:0]        w_thr;

    // Front stages, all advancing together.
    assign w_bb = r1_b * r1_b;
    assign w_ac = $signed({{qrs_pkg::DW{r1_a[qrs_pkg::DW-1]}}, r1_a})
                * $signed({{qrs_pkg::DW{r1_c[qrs_pkg::DW-1]}}, r1_c});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
            r3_v <= 1'b0;
            r4_v <= 1'b0;
            r5_v <= 1'b0;
        end else if (w_en) begin
            r1_v <= i_valid;
            r2_v <= r1_v;
            r3_v <= r2_v;
            r4_v <= r3_v;
            r5_v <= r4_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r1_a   <= i_coef_a;
            r1_b   <= i_coef_b;
            r1_c   <= i_coef_c;
            r1_nza <= near_zero(i_coef_a, r_tol);
            r1_nzb <= near_zero(i_coef_b, r_tol);
            r1_nzc <= near_zero(i_coef_c, r_tol);

            r2_bb  <= w_bb;
            r2_ac  <= w_ac;
            r2_a   <= r1_a;
            r2_b   <= r1_b;
            r2_c   <= r1_c;
            r2_nza <= r1_nza;
            r2_nzb <= r1_nzb;
            r2_nzc <= r1_nzc;

            r3_e   <= $signed({2'b00, r2_bb[qrs_pkg::PROD_W-1:2]}) - r2_ac;
            r3_r   <= r2_b[0];
            r3_a   <= r2_a;
            r3_b   <= r2_b;
            r3_c   <= r2_c;
            r3_nza <= r2_nza;
            r3_nzb <= r2_nzb;
            r3_nzc <= r2_nzc;

            r4_me    <= r3_e[qrs_pkg::PROD_W-1] ? (-r3_e) : r3_e;
            r4_eneg  <= r3_e[qrs_pkg::PROD_W-1];
            r4_ezero <= (r3_e == '0);
            r4_r     <= r3_r;
            r4_d     <= r3_e[qrs_pkg::PROD_W-1] ? '0
                        : {r3_e[qrs_pkg::D_W-3:0], 1'b0, r3_r};
            r4_a     <= r3_a;
            r4_b     <= r3_b;
            r4_c     <= r3_c;
            r4_nza   <= r3_nza;
            r4_nzb   <= r3_nzb;
            r4_nzc   <= r3_nzc;

            r5_side <= w_side;
            r5_d    <= r4_d;
        end
    end

    // Discriminant tolerance test and case selection.
    assign w_small = (r4_me[qrs_pkg::PROD_W-1:qrs_pkg::THR_W] == '0);
    assign w_thr   = {r_tol, {qrs_pkg::FB{1'b0}}};
    assign w_val   = r4_eneg
                   ? ({r4_me[qrs_pkg::THR_W-1:0], 2'b00} - {{(qrs_pkg::THR_W+1){1'b0}}, r4_r})
                   : ({r4_me[qrs_pkg::THR_W-1:0], 2'b00} + {{(qrs_pkg::THR_W+1){1'b0}}, r4_r});
    assign w_dzero = (r4_ezero && !r4_r)
                   || (w_small && (w_val < {2'b00, w_thr}));

    always_comb begin
        w_side.a     = r4_a;
        w_side.b     = r4_b;
        w_side.c     = r4_c;
        w_side.count = qrs_pkg::CNT_NONE;
        w_side.mode  = qrs_pkg::MODE_ZERO;
        if (r4_nza) begin
            if (r4_nzb) begin
                w_side.count = r4_nzc ? qrs_pkg::CNT_INF : qrs_pkg::CNT_NONE;
            end else begin
                w_side.count = qrs_pkg::CNT_ONE;
                w_side.mode  = r4_nzc ? qrs_pkg::MODE_ZERO : qrs_pkg::MODE_LIN;
            end
        end else if (w_dzero) begin
            w_side.count = qrs_pkg::CNT_ONE;
            w_side.mode  = r4_nzb ? qrs_pkg::MODE_ZERO : qrs_pkg::MODE_DBL;
        end else if (r4_eneg) begin
            w_side.count = qrs_pkg::CNT_NONE;
        end else if (r4_nzc) begin
            w_side.count = qrs_pkg::CNT_TWO;
            w_side.mode  = r4_nzb ? qrs_pkg::MODE_ZERO : qrs_pkg::MODE_CZERO;
        end else begin
            w_side.count = qrs_pkg::CNT_TWO;
            w_side.mode  = qrs_pkg::MODE_TWO;
        end
    end

    // Integer square root of D.
    logic                             sq_v;
    logic [qrs_pkg::ROOT_W-1:0]       sq_root;
    qrs_pkg::t_sq_side                sq_side;

    qrs_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r5_v),
        .i_rad   (r5_d),
        .i_side  (r5_side),
        .o_valid (sq_v),
        .o_root  (sq_root),
        .o_side  (sq_side)
    );

    // Stage 6: signed numerators and denominators of both lanes.
    logic signed [qrs_pkg::NUM_W:0]   w_sb, w_sc, w_rs, w_nplus, w_nminus, w_nb, w_nc;
    logic signed [qrs_pkg::DEN_W:0]   w_d2a, w_da, w_db, w_one;
    logic signed [qrs_pkg::NUM_W:0]   w_n [qrs_pkg::LANES];
    logic signed [qrs_pkg::DEN_W:0]   w_d [qrs_pkg::LANES];
    logic                             r6_v;
    logic signed [qrs_pkg::NUM_W:0]   r6_n [qrs_pkg::LANES];
    logic signed [qrs_pkg::DEN_W:0]   r6_d [qrs_pkg::LANES];
    logic [1:0]                       r6_count;

    assign w_sb = {{(qrs_pkg::NUM_W+1-qrs_pkg::DW){sq_side.b[qrs_pkg::DW-1]}}, sq_side.b};
    assign w_sc = {{(qrs_pkg::NUM_W+1-qrs_pkg::DW){sq_side.c[qrs_pkg::DW-1]}}, sq_side.c};
    assign w_rs = {{(qrs_pkg::NUM_W+1-qrs_pkg::ROOT_W){1'b0}}, sq_root};
    assign w_nplus  = w_rs - w_sb;
    assign w_nminus = -w_sb - w_rs;
    assign w_nb     = -w_sb;
    assign w_nc     = -w_sc;
    assign w_d2a = {sq_side.a[qrs_pkg::DW-1], sq_side.a, 1'b0};
    assign w_da  = {{(qrs_pkg::DEN_W+1-qrs_pkg::DW){sq_side.a[qrs_pkg::DW-1]}}, sq_side.a};
    assign w_db  = {{(qrs_pkg::DEN_W+1-qrs_pkg::DW){sq_side.b[qrs_pkg::DW-1]}}, sq_side.b};
    assign w_one = {{qrs_pkg::DEN_W{1'b0}}, 1'b1};

    always_comb begin
        w_n[0] = '0;
        w_d[0] = w_one;
        w_n[1] = '0;
        w_d[1] = w_one;
        case (sq_side.mode)
            qrs_pkg::MODE_ZERO: begin
                w_n[0] = '0;
                w_d[0] = w_one;
            end
            qrs_pkg::MODE_LIN: begin
                w_n[0] = w_nc;
                w_d[0] = w_db;
                w_n[1] = w_nc;
                w_d[1] = w_db;
            end
            qrs_pkg::MODE_DBL: begin
                w_n[0] = w_nb;
                w_d[0] = w_d2a;
                w_n[1] = w_nb;
                w_d[1] = w_d2a;
            end
            qrs_pkg::MODE_CZERO: begin
                w_n[1] = w_nb;
                w_d[1] = w_da;
            end
            qrs_pkg::MODE_TWO: begin
                w_n[0] = w_nplus;
                w_d[0] = w_d2a;
                w_n[1] = w_nminus;
                w_d[1] = w_d2a;
            end
            default: begin
                w_n[0] = '0;
                w_d[0] = w_one;
            end
        endcase
    end

    // Stage 7: sign and magnitude for the dividers.
    logic                             r7_v;
    qrs_pkg::t_lane                   r7_lane [qrs_pkg::LANES];
    logic [1:0]                       r7_count;
    qrs_pkg::t_lane                   w_lane [qrs_pkg::LANES];
    logic [qrs_pkg::NUM_W:0]          w_nm [qrs_pkg::LANES];
    logic [qrs_pkg::DEN_W:0]          w_dm [qrs_pkg::LANES];

    for (genvar l = 0; l < qrs_pkg::LANES; l++) begin : g_mag
        assign w_nm[l] = r6_n[l][qrs_pkg::NUM_W] ? (-r6_n[l]) : r6_n[l];
        assign w_dm[l] = r6_d[l][qrs_pkg::DEN_W] ? (-r6_d[l]) : r6_d[l];
        assign w_lane[l] = '{neg: r6_n[l][qrs_pkg::NUM_W] ^ r6_d[l][qrs_pkg::DEN_W],
                             num_mag: w_nm[l][qrs_pkg::NUM_W-1:0],
                             den_mag: w_dm[l][qrs_pkg::DEN_W-1:0]};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r6_v <= 1'b0;
            r7_v <= 1'b0;
        end else if (w_en) begin
            r6_v <= sq_v;
            r7_v <= r6_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r6_count <= sq_side.count;
            r7_count <= r6_count;
            for (int l = 0; l < qrs_pkg::LANES; l++) begin
                r6_n[l]    <= w_n[l];
                r6_d[l]    <= w_d[l];
                r7_lane[l] <= w_lane[l];
            end
        end
    end

    // Fixed-point quotients of both lanes.
    logic                             dv_v;
    qrs_pkg::t_quo                    dv_quo [qrs_pkg::LANES];
    logic [1:0]                       dv_count;

    qrs_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r7_v),
        .i_lane  (r7_lane),
        .i_count (r7_count),
        .o_valid (dv_v),
        .o_quo   (dv_quo),
        .o_count (dv_count)
    );

    // Clip into the word range.
    logic [qrs_pkg::DW:0]             w_c0, w_c1;
    t_result                          w_res;

    assign w_c0 = clip_quo(dv_quo[0]);
    assign w_c1 = clip_quo(dv_quo[1]);
    assign w_res = '{count: dv_count,
                     first: w_c0[qrs_pkg::DW-1:0],
                     second: w_c1[qrs_pkg::DW-1:0],
                     sat: w_c0[qrs_pkg::DW] | w_c1[qrs_pkg::DW]};

    // Output register with one skid entry behind it.
    logic                             r_out_v, r_skid_v;
    t_result                          r_out, r_skid;

    assign w_en    = !r_skid_v;
    assign o_stall = r_skid_v;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else if (r_skid_v) begin
            if (!i_stall) begin
                r_skid_v <= 1'b0;
            end
        end else if (!r_out_v || !i_stall) begin
            r_out_v <= dv_v;
        end else if (dv_v) begin
            r_skid_v <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_v) begin
            if (!i_stall) begin
                r_out <= r_skid;
            end
        end else if (!r_out_v || !i_stall) begin
            r_out <= w_res;
        end else begin
            r_skid <= w_res;
        end
    end

    assign o_valid       = r_out_v;
    assign o_root_count  = r_out.count;
    assign o_root_first  = r_out.first;
    assign o_root_second = r_out.second;
    assign o_saturated   = r_out.sat;

    // Checks on the output stage and root encoding.
    `QRS_ASSERT(a_skid_behind_out, i_clk, i_rst_n, r_skid_v |-> r_out_v, "skid full while output empty")
    `QRS_ASSERT_NEXT(a_skid_holds, i_clk, i_rst_n, r_skid_v && i_stall, r_skid_v && o_stall, "skid beat lost under stall")
    `QRS_ASSERT(a_no_root_zero, i_clk, i_rst_n, (o_valid && (o_root_count == qrs_pkg::CNT_NONE || o_root_count == qrs_pkg::CNT_INF)) |-> (o_root_first == '0 && o_root_second == '0), "absent roots not zero")
    `QRS_ASSERT(a_single_same, i_clk, i_rst_n, (o_valid && o_root_count == qrs_pkg::CNT_ONE) |-> (o_root_first == o_root_second), "single root differs between outputs")
    `QRS_ASSERT(a_sat_extreme, i_clk, i_rst_n, (o_valid && o_saturated) |-> (o_root_first == qrs_pkg::WORD_MAX || o_root_first == qrs_pkg::WORD_MIN || o_root_second == qrs_pkg::WORD_MAX || o_root_second == qrs_pkg::WORD_MIN), "saturation without a clipped root")

endmodule
